FILE: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define PIDCD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pidcd assertion failed");

// clocked assertion that also runs during reset
`define PIDCD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pidcd assertion failed");

`endif

FILE: sv/pidcd_pkg.sv
// types, constants and helpers of the dual-mode pid controller
package pidcd_pkg;

  localparam int ValueW   = 32;
  localparam int FracBits = 16;
  localparam int ErrW     = ValueW + 1;
  localparam int DiffW    = ValueW + 2;
  localparam int OpW      = ValueW + 3;
  localparam int ProdW    = ValueW + OpW;
  localparam int TermW    = ProdW - FracBits;
  localparam int SumW     = TermW + 2;
  localparam int AccW     = SumW + 1;
  localparam int MsW      = 32;
  localparam int PeriodW  = 16;
  localparam int LimW     = ValueW - 1;
  localparam int CfgIdxW  = 3;

  localparam logic signed [ValueW-1:0] OutMaxRst = ValueW'(1000 << FracBits);
  localparam logic signed [ValueW-1:0] OutMinRst = -OutMaxRst;
  localparam logic [LimW-1:0]          IntLimRst = LimW'(1000 << FracBits);
  localparam logic [PeriodW-1:0]       PeriodRst = PeriodW'(10);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_OUT_MIN     = 3'd3,
    CFG_OUT_MAX     = 3'd4,
    CFG_INT_LIMIT   = 3'd5,
    CFG_SAMPLE_MS   = 3'd6,
    CFG_LOOP_MODE   = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    CMD_COMPUTE = 1'b0,
    CMD_RESET   = 1'b1
  } command_e;

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } loop_mode_e;

  typedef enum logic [1:0] {
    KIND_HOLD   = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_RESET  = 2'd2
  } item_kind_e;

  typedef struct packed {
    command_e                  command;
    logic signed [ValueW-1:0]  setpoint;
    logic signed [ValueW-1:0]  measured;
    logic [MsW-1:0]            now_ms;
  } pid_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0]  drive;
    logic                      updated;
  } pid_out_t;

  // saturate a wide signed value into [lo, hi]
  function automatic logic signed [ValueW-1:0] clamp_val(
    input logic signed [AccW-1:0]   v,
    input logic signed [ValueW-1:0] lo,
    input logic signed [ValueW-1:0] hi
  );
    logic signed [ValueW-1:0] r;
    if (v > AccW'(hi)) begin
      r = hi;
    end else if (v < AccW'(lo)) begin
      r = lo;
    end else begin
      r = ValueW'(v);
    end
    return r;
  endfunction

endpackage

FILE: sv/pid_controller_dual_mode.sv
// dual-mode (positional / incremental) pid controller, q16.16, pipelined
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  in       | input     | in_valid_i / in_ready_o   | in_data_i  (pid_in_t)
//  out      | output    | out_valid_o / out_ready_i | out_data_o (pid_out_t)
//  cfg      | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// one transaction enters per cycle while in_ready_o is high; a taken input passes
// the input register, operand stage, three 32x35 multipliers, term sum,
// then the held-output add and clamp into the output register
// the controller state updates in single stages (history at the operand stage,
// held output at the last stage), so back-to-back transactions see each other
// reset is asynchronous active low and clears all control and controller state
// a stall on out_ready_i fills bubbles first; in_ready_o drops only when all
// stages hold a transaction and the output is not taken
module pid_controller_dual_mode import pidcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pid_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pid_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ValueW-1:0]  cfg_data_i
);

  // configuration registers
  logic signed [ValueW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [ValueW-1:0] out_min_q, out_max_q;
  logic [LimW-1:0]          int_lim_q;
  logic [PeriodW-1:0]       period_q;
  loop_mode_e               mode_q;

  // controller state
  logic signed [ValueW-1:0] integ_q, integ_d;
  logic signed [ErrW-1:0]   err1_q, err1_d, err2_q, err2_d;
  logic [MsW-1:0]           last_ms_q, last_ms_d;
  logic signed [ValueW-1:0] held_q, held_d;

  // pipeline slots: a input, b operands, c products, d sum, o output
  logic va_q, vb_q, vc_q, vd_q, vo_q;
  logic free_a, free_b, free_c, free_d, free_o;
  logic move_a, move_b, move_c, move_d;

  pid_in_t                  a_data_q;
  item_kind_e               b_kind_q, c_kind_q, d_kind_q;
  logic signed [OpW-1:0]    b_op_p_q, b_op_i_q, b_op_d_q;
  logic signed [ProdW-1:0]  c_prod_p_q, c_prod_i_q, c_prod_d_q;
  logic signed [SumW-1:0]   d_sum_q;
  pid_out_t                 o_data_q;

  // ---------------------------------------------------------------------------
  // handshake: each slot frees when empty or when its transaction moves on
  // ---------------------------------------------------------------------------
  assign free_o = !vo_q || out_ready_i;
  assign move_d = vd_q && free_o;
  assign free_d = !vd_q || move_d;
  assign move_c = vc_q && free_d;
  assign free_c = !vc_q || move_c;
  assign move_b = vb_q && free_c;
  assign free_b = !vb_q || move_b;
  assign move_a = va_q && free_b;
  assign free_a = !va_q || move_a;

  assign in_ready_o  = free_a;
  assign out_valid_o = vo_q;
  assign out_data_o  = o_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (free_a) va_q <= in_valid_i;
      if (free_b) vb_q <= va_q;
      if (free_c) vc_q <= vb_q;
      if (free_d) vd_q <= vc_q;
      if (free_o) vo_q <= vd_q;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  cfg_reg_e                 cfg_idx;
  logic signed [ValueW-1:0] lim_lo, lim_hi;
  logic                     lim_wr, lim_ok, mode_chg;

  assign cfg_idx  = cfg_reg_e'(cfg_idx_i);
  assign lim_lo   = (cfg_idx == CFG_OUT_MIN) ? signed'(cfg_data_i) : out_min_q;
  assign lim_hi   = (cfg_idx == CFG_OUT_MAX) ? signed'(cfg_data_i) : out_max_q;
  assign lim_wr   = cfg_we_i && (cfg_idx == CFG_OUT_MIN || cfg_idx == CFG_OUT_MAX);
  // a limit pair that is not strictly ordered is dropped
  assign lim_ok   = lim_lo < lim_hi;
  assign mode_chg = cfg_we_i && (cfg_idx == CFG_LOOP_MODE) &&
                    (loop_mode_e'(cfg_data_i[0]) != mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= '0;
      gain_i_q  <= '0;
      gain_d_q  <= '0;
      out_min_q <= OutMinRst;
      out_max_q <= OutMaxRst;
      int_lim_q <= IntLimRst;
      period_q  <= PeriodRst;
      mode_q    <= MODE_POSITIONAL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CFG_GAIN_P:    gain_p_q  <= signed'(cfg_data_i);
        CFG_GAIN_I:    gain_i_q  <= signed'(cfg_data_i);
        CFG_GAIN_D:    gain_d_q  <= signed'(cfg_data_i);
        CFG_OUT_MIN,
        CFG_OUT_MAX: begin
          if (lim_ok) begin
            out_min_q <= lim_lo;
            out_max_q <= lim_hi;
          end
        end
        CFG_INT_LIMIT: int_lim_q <= cfg_data_i[LimW-1:0];
        CFG_SAMPLE_MS: period_q  <= cfg_data_i[PeriodW-1:0];
        CFG_LOOP_MODE: mode_q    <= loop_mode_e'(cfg_data_i[0]);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // slot a: input register, sample-time check, error and operand forming
  // ---------------------------------------------------------------------------
  logic [MsW-1:0]           elapsed;
  logic                     due;
  logic signed [ErrW-1:0]   err;
  logic signed [DiffW-1:0]  d1;
  logic signed [OpW-1:0]    d2;
  logic signed [DiffW-1:0]  integ_sum, lim_pos, lim_neg;
  logic signed [ValueW-1:0] integ_new;
  logic signed [OpW-1:0]    op_p, op_i, op_d;
  item_kind_e               a_kind;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && free_a) a_data_q <= in_data_i;
  end

  // elapsed time wraps modulo 2^32
  assign elapsed = a_data_q.now_ms - last_ms_q;
  assign due     = elapsed >= MsW'(period_q);

  assign err = ErrW'(a_data_q.setpoint) - ErrW'(a_data_q.measured);
  assign d1  = DiffW'(err) - DiffW'(err1_q);
  // e - 2*e1 + e2 as (e - e1) - e1 + e2
  assign d2  = OpW'(d1) - OpW'(err1_q) + OpW'(err2_q);

  assign integ_sum = DiffW'(integ_q) + DiffW'(err);
  assign lim_pos   = signed'(DiffW'(int_lim_q));
  assign lim_neg   = -lim_pos;

  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_new = ValueW'(lim_pos);
    end else if (integ_sum < lim_neg) begin
      integ_new = ValueW'(lim_neg);
    end else begin
      integ_new = ValueW'(integ_sum);
    end
  end

  always_comb begin
    if (mode_q == MODE_POSITIONAL) begin
      op_p = OpW'(err);
      op_i = OpW'(integ_new);
      op_d = OpW'(d1);
    end else begin
      op_p = OpW'(d1);
      op_i = OpW'(err);
      op_d = d2;
    end
  end

  always_comb begin
    if (a_data_q.command == CMD_RESET) begin
      a_kind = KIND_RESET;
    end else if (due) begin
      a_kind = KIND_UPDATE;
    end else begin
      a_kind = KIND_HOLD;
    end
  end

  // history: integral, past errors and time stamp
  always_comb begin
    integ_d   = integ_q;
    err1_d    = err1_q;
    err2_d    = err2_q;
    last_ms_d = last_ms_q;
    if (cfg_we_i) begin
      if (lim_wr && lim_ok) begin
        integ_d = clamp_val(AccW'(integ_q), lim_lo, lim_hi);
      end
      if (mode_chg) begin
        integ_d = '0;
        err1_d  = '0;
        err2_d  = '0;
      end
    end else if (move_a) begin
      unique case (a_kind)
        KIND_RESET: begin
          integ_d   = '0;
          err1_d    = '0;
          err2_d    = '0;
          last_ms_d = a_data_q.now_ms;
        end
        KIND_UPDATE: begin
          if (mode_q == MODE_POSITIONAL) begin
            integ_d = integ_new;
          end else begin
            err2_d = err1_q;
          end
          err1_d    = err;
          last_ms_d = a_data_q.now_ms;
        end
        KIND_HOLD: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q   <= '0;
      err1_q    <= '0;
      err2_q    <= '0;
      last_ms_q <= '0;
    end else begin
      integ_q   <= integ_d;
      err1_q    <= err1_d;
      err2_q    <= err2_d;
      last_ms_q <= last_ms_d;
    end
  end

  // ---------------------------------------------------------------------------
  // slot b -> c: three products, one multiplier each
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (move_a) begin
      b_kind_q <= a_kind;
      b_op_p_q <= op_p;
      b_op_i_q <= op_i;
      b_op_d_q <= op_d;
    end
    if (move_b) begin
      c_kind_q   <= b_kind_q;
      c_prod_p_q <= gain_p_q * b_op_p_q;
      c_prod_i_q <= gain_i_q * b_op_i_q;
      c_prod_d_q <= gain_d_q * b_op_d_q;
    end
  end

  // ---------------------------------------------------------------------------
  // slot c -> d: floor shift by the fraction bits and sum of the terms
  // the terms stay within the 2^50 magnitude cap at these widths
  // ---------------------------------------------------------------------------
  logic signed [TermW-1:0] term_p, term_i, term_d;

  assign term_p = TermW'(c_prod_p_q >>> FracBits);
  assign term_i = TermW'(c_prod_i_q >>> FracBits);
  assign term_d = TermW'(c_prod_d_q >>> FracBits);

  always_ff @(posedge clk_i) begin
    if (move_c) begin
      d_kind_q <= c_kind_q;
      d_sum_q  <= SumW'(term_p) + SumW'(term_i) + SumW'(term_d);
    end
  end

  // ---------------------------------------------------------------------------
  // slot d -> o: add held output in incremental mode, clamp, hold
  // ---------------------------------------------------------------------------
  logic signed [AccW-1:0]   acc;
  logic signed [ValueW-1:0] drive_new;

  assign acc = AccW'(d_sum_q) +
               ((mode_q == MODE_INCREMENTAL) ? AccW'(held_q) : AccW'(0));
  assign drive_new = clamp_val(acc, out_min_q, out_max_q);

  always_comb begin
    held_d = held_q;
    if (cfg_we_i) begin
      if (lim_wr && lim_ok) begin
        held_d = clamp_val(AccW'(held_q), lim_lo, lim_hi);
      end
      if (mode_chg) begin
        held_d = '0;
      end
    end else if (move_d) begin
      unique case (d_kind_q)
        KIND_UPDATE: held_d = drive_new;
        KIND_RESET:  held_d = '0;
        KIND_HOLD:   ;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_d) begin
      o_data_q.drive   <= held_d;
      o_data_q.updated <= (d_kind_q == KIND_UPDATE);
    end
  end

endmodule

FILE: sv/pidcd_checker.sv
// port-level checker of the pid controller, bound to the top level
`include "assert_macros.svh"

module pidcd_checker import pidcd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input pid_out_t out_data_o
);

  // a waiting result keeps its valid and payload
  `PIDCD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // input back-pressure only comes from a result that is not taken
  `PIDCD_ASSERT(a_stall_source, clk_i, rst_ni, !in_ready_o |-> out_valid_o)

  // with the output drained while it passes the slots, a taken transaction
  // reaches the output register and shows valid there
  `PIDCD_ASSERT(a_latency, clk_i, rst_ni, in_valid_i && in_ready_o ##1 out_ready_i [*4] |=> out_valid_o)

  // no result right after reset release
  `PIDCD_ASSERT(a_reset_empty, clk_i, rst_ni, $rose(rst_ni) |=> !out_valid_o)

endmodule

bind pid_controller_dual_mode pidcd_checker u_pidcd_checker (.*);
